[src/cbtc_pkg.sv]
// ----------------------------------------------------------------------------
// cbtc_pkg: shared definitions for the color box threshold centroid block
// Register indexes, reset values, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package cbtc_pkg;

    // Default geometry limits.
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 1024;

    // Fixed field widths.
    localparam int CHAN_W   = 8;
    localparam int IMG_W_W  = 11;
    localparam int CFG_D_W  = 11;
    localparam int CFG_I_W  = 3;
    localparam int CNT_W    = 21;
    localparam int SUM_W    = 30;
    localparam int CENT_W   = 10;
    localparam int INDEX_W  = 20;

    // Configuration register indexes.
    localparam logic [CFG_I_W-1:0] REG_RED_LOW     = 3'd0;
    localparam logic [CFG_I_W-1:0] REG_RED_HIGH    = 3'd1;
    localparam logic [CFG_I_W-1:0] REG_GREEN_LOW   = 3'd2;
    localparam logic [CFG_I_W-1:0] REG_GREEN_HIGH  = 3'd3;
    localparam logic [CFG_I_W-1:0] REG_BLUE_LOW    = 3'd4;
    localparam logic [CFG_I_W-1:0] REG_BLUE_HIGH   = 3'd5;
    localparam logic [CFG_I_W-1:0] REG_IMAGE_WIDTH = 3'd6;

    // Register reset values.
    localparam logic [CHAN_W-1:0]  RST_RED_LOW     = 8'd200;
    localparam logic [CHAN_W-1:0]  RST_RED_HIGH    = 8'd255;
    localparam logic [CHAN_W-1:0]  RST_GREEN_LOW   = 8'd0;
    localparam logic [CHAN_W-1:0]  RST_GREEN_HIGH  = 8'd90;
    localparam logic [CHAN_W-1:0]  RST_BLUE_LOW    = 8'd0;
    localparam logic [CHAN_W-1:0]  RST_BLUE_HIGH   = 8'd200;
    localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH = 11'd640;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_COL,
        S_DIV_ROW,
        S_MUL,
        S_OUT
    } t_state;

endpackage

[src/color_box_threshold_centroid.sv]
// ----------------------------------------------------------------------------
// color_box_threshold_centroid: RGB box threshold with blob centroid
// Flags pixels inside a per-channel byte box and reports the match count and
// mean position of the flagged pixels at the end of each frame.
// ----------------------------------------------------------------------------
// Pixels that do not close a frame pass at one word per clock while the output
// is not held back: each gets its match flag in the cycle after it is taken,
// and a new pixel is taken while the previous result leaves the output register.
// The input is not ready while the end-of-frame pixel is processed: one
// shared restoring divider produces one quotient bit per cycle, first for the
// column sum and then for the row sum, and a final step forms the row-major
// index with a single small multiply. Accumulators clear when that pixel is
// taken, so the next frame may start as soon as the report is accepted.
module color_box_threshold_centroid
    import cbtc_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [CFG_I_W-1:0]  i_cfg_index,
    input  logic [CFG_D_W-1:0]  i_cfg_data,
    // pixel input
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CHAN_W-1:0]   i_red,
    input  logic [CHAN_W-1:0]   i_green,
    input  logic [CHAN_W-1:0]   i_blue,
    input  logic                i_end_of_frame,
    // result output
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_pixel_match,
    output logic                o_frame_done,
    output logic                o_object_found,
    output logic [CNT_W-1:0]    o_match_count,
    output logic [CENT_W-1:0]   o_centroid_column,
    output logic [CENT_W-1:0]   o_centroid_row,
    output logic [INDEX_W-1:0]  o_centroid_index
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int EW_W   = $clog2(MAX_COLUMNS + 1);
    localparam int CMP_W  = (EW_W > IMG_W_W) ? EW_W : IMG_W_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int IDX_W  = ROW_W + EW_W + 1;

    localparam logic [CMP_W-1:0]  MAX_COL_CMP = CMP_W'(MAX_COLUMNS);
    localparam logic [SUM_W-1:0]  ROW_LAST    = SUM_W'(MAX_ROWS - 1);
    localparam logic [ROW_W-1:0]  ROW_TOP     = ROW_W'(MAX_ROWS - 1);
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(SUM_W - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX     = {SUM_W{1'b1}};

    // configuration registers
    logic [CHAN_W-1:0]  r_red_low, r_red_high, r_green_low, r_green_high;
    logic [CHAN_W-1:0]  r_blue_low, r_blue_high;
    logic [IMG_W_W-1:0] r_image_width;

    // frame accumulators
    logic [COL_W-1:0] r_col_pos, n_col_pos;
    logic [ROW_W-1:0] r_row_pos, n_row_pos;
    logic [CNT_W-1:0] r_hit_count, n_hit_count;
    logic [SUM_W-1:0] r_col_sum, n_col_sum;
    logic [SUM_W-1:0] r_row_sum, n_row_sum;

    // end-of-frame sequencer and divider
    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [SUM_W-1:0]  r_row_total, n_row_total;
    logic [EW_W-1:0]   r_frame_w, n_frame_w;
    logic              r_eof_match, n_eof_match;
    logic [COL_W-1:0]  r_cc, n_cc;
    logic [ROW_W-1:0]  r_cr, n_cr;
    logic [INDEX_W-1:0] r_idx, n_idx;

    // output register
    logic               r_out_valid, n_out_valid;
    logic               r_o_match, n_o_match;
    logic               r_o_done, n_o_done;
    logic               r_o_found, n_o_found;
    logic [CNT_W-1:0]   r_o_count, n_o_count;
    logic [CENT_W-1:0]  r_o_col, n_o_col;
    logic [CENT_W-1:0]  r_o_row, n_o_row;
    logic [INDEX_W-1:0] r_o_idx, n_o_idx;

    // combinational helpers
    logic [CMP_W-1:0]   img_cmp;
    logic [EW_W-1:0]    eff_w;
    logic               match;
    logic               in_take;
    logic               out_free;
    logic [CNT_W:0]     cnt_inc;
    logic [SUM_W:0]     col_add, row_add;
    logic [CNT_W:0]     trial;
    logic               q_bit;
    logic [SUM_W-1:0]   quo_next;
    logic [SUM_W-1:0]   w_last;
    logic [IDX_W-1:0]   idx_full;

    // Width 0 behaves as 1, anything above the limit as the limit.
    assign img_cmp = CMP_W'(r_image_width);
    assign eff_w   = (img_cmp == '0) ? EW_W'(1) :
                     (img_cmp > MAX_COL_CMP) ? EW_W'(MAX_COLUMNS) : EW_W'(img_cmp);

    assign match = (i_red   >= r_red_low)   && (i_red   <= r_red_high)   &&
                   (i_green >= r_green_low) && (i_green <= r_green_high) &&
                   (i_blue  >= r_blue_low)  && (i_blue  <= r_blue_high);

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_take    = i_in_valid && o_in_ready;

    // Saturating accumulator updates for a matching pixel.
    assign cnt_inc = {1'b0, r_hit_count} + (CNT_W + 1)'(1);
    assign col_add = {1'b0, r_col_sum} + (SUM_W + 1)'(r_col_pos);
    assign row_add = {1'b0, r_row_sum} + (SUM_W + 1)'(r_row_pos);

    // One restoring division step: one quotient bit per cycle.
    assign trial    = {r_rem, r_quo[SUM_W-1]};
    assign q_bit    = (trial >= {1'b0, r_div_cnt});
    assign quo_next = {r_quo[SUM_W-2:0], q_bit};
    assign w_last   = SUM_W'(r_frame_w) - SUM_W'(1);

    assign idx_full = IDX_W'(r_cr) * IDX_W'(r_frame_w) + IDX_W'(r_cc);

    always_comb begin
        n_state     = r_state;
        n_col_pos   = r_col_pos;
        n_row_pos   = r_row_pos;
        n_hit_count = r_hit_count;
        n_col_sum   = r_col_sum;
        n_row_sum   = r_row_sum;
        n_step      = r_step;
        n_div_cnt   = r_div_cnt;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_row_total = r_row_total;
        n_frame_w   = r_frame_w;
        n_eof_match = r_eof_match;
        n_cc        = r_cc;
        n_cr        = r_cr;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_match   = r_o_match;
        n_o_done    = r_o_done;
        n_o_found   = r_o_found;
        n_o_count   = r_o_count;
        n_o_col     = r_o_col;
        n_o_row     = r_o_row;
        n_o_idx     = r_o_idx;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (match) begin
                        n_hit_count = cnt_inc[CNT_W] ? CNT_MAX : cnt_inc[CNT_W-1:0];
                        n_col_sum   = col_add[SUM_W] ? SUM_MAX : col_add[SUM_W-1:0];
                        n_row_sum   = row_add[SUM_W] ? SUM_MAX : row_add[SUM_W-1:0];
                    end
                    if (i_end_of_frame) begin
                        // Freeze the frame totals for the divider and clear.
                        n_div_cnt   = n_hit_count;
                        n_quo       = n_col_sum;
                        n_row_total = n_row_sum;
                        n_rem       = '0;
                        n_step      = '0;
                        n_frame_w   = eff_w;
                        n_eof_match = match;
                        n_col_pos   = '0;
                        n_row_pos   = '0;
                        n_hit_count = '0;
                        n_col_sum   = '0;
                        n_row_sum   = '0;
                        n_state     = S_DIV_COL;
                    end else begin
                        if ((EW_W + 1)'(r_col_pos) + (EW_W + 1)'(1) >= (EW_W + 1)'(eff_w)) begin
                            n_col_pos = '0;
                            if (r_row_pos != ROW_TOP) begin
                                n_row_pos = r_row_pos + ROW_W'(1);
                            end
                        end else begin
                            n_col_pos = r_col_pos + COL_W'(1);
                        end
                        n_out_valid = 1'b1;
                        n_o_match   = match;
                        n_o_done    = 1'b0;
                        n_o_found   = 1'b0;
                        n_o_count   = '0;
                        n_o_col     = '0;
                        n_o_row     = '0;
                        n_o_idx     = '0;
                    end
                end
            end
            S_DIV_COL: begin
                n_rem  = q_bit ? CNT_W'(trial - {1'b0, r_div_cnt}) : CNT_W'(trial);
                n_quo  = quo_next;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_cc    = COL_W'((quo_next > w_last) ? w_last : quo_next);
                    n_quo   = r_row_total;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = S_DIV_ROW;
                end
            end
            S_DIV_ROW: begin
                n_rem  = q_bit ? CNT_W'(trial - {1'b0, r_div_cnt}) : CNT_W'(trial);
                n_quo  = quo_next;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_cr    = ROW_W'((quo_next > ROW_LAST) ? ROW_LAST : quo_next);
                    n_step  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_idx   = INDEX_W'(idx_full);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    // A frame with no match reports zeros in every statistic.
                    n_out_valid = 1'b1;
                    n_o_match   = r_eof_match;
                    n_o_done    = 1'b1;
                    n_o_found   = (r_div_cnt != '0);
                    n_o_count   = r_div_cnt;
                    n_o_col     = (r_div_cnt != '0) ? CENT_W'(r_cc) : '0;
                    n_o_row     = (r_div_cnt != '0) ? CENT_W'(r_cr) : '0;
                    n_o_idx     = (r_div_cnt != '0) ? r_idx : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_col_pos   <= '0;
            r_row_pos   <= '0;
            r_hit_count <= '0;
            r_col_sum   <= '0;
            r_row_sum   <= '0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_col_pos   <= n_col_pos;
            r_row_pos   <= n_row_pos;
            r_hit_count <= n_hit_count;
            r_col_sum   <= n_col_sum;
            r_row_sum   <= n_row_sum;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_cnt   <= n_div_cnt;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_row_total <= n_row_total;
        r_frame_w   <= n_frame_w;
        r_eof_match <= n_eof_match;
        r_cc        <= n_cc;
        r_cr        <= n_cr;
        r_idx       <= n_idx;
        r_o_match   <= n_o_match;
        r_o_done    <= n_o_done;
        r_o_found   <= n_o_found;
        r_o_count   <= n_o_count;
        r_o_col     <= n_o_col;
        r_o_row     <= n_o_row;
        r_o_idx     <= n_o_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_low     <= RST_RED_LOW;
            r_red_high    <= RST_RED_HIGH;
            r_green_low   <= RST_GREEN_LOW;
            r_green_high  <= RST_GREEN_HIGH;
            r_blue_low    <= RST_BLUE_LOW;
            r_blue_high   <= RST_BLUE_HIGH;
            r_image_width <= RST_IMAGE_WIDTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RED_LOW:     r_red_low     <= i_cfg_data[CHAN_W-1:0];
                REG_RED_HIGH:    r_red_high    <= i_cfg_data[CHAN_W-1:0];
                REG_GREEN_LOW:   r_green_low   <= i_cfg_data[CHAN_W-1:0];
                REG_GREEN_HIGH:  r_green_high  <= i_cfg_data[CHAN_W-1:0];
                REG_BLUE_LOW:    r_blue_low    <= i_cfg_data[CHAN_W-1:0];
                REG_BLUE_HIGH:   r_blue_high   <= i_cfg_data[CHAN_W-1:0];
                REG_IMAGE_WIDTH: r_image_width <= i_cfg_data[IMG_W_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pixel_match     = r_o_match;
    assign o_frame_done      = r_o_done;
    assign o_object_found    = r_o_found;
    assign o_match_count     = r_o_count;
    assign o_centroid_column = r_o_col;
    assign o_centroid_row    = r_o_row;
    assign o_centroid_index  = r_o_idx;

    // The end-of-frame word starts the divider and clears the match count and position.
    a_eof_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_end_of_frame) |=>
            (r_state == S_DIV_COL) && (r_hit_count == '0) && (r_col_pos == '0)
            && (r_row_pos == '0))
        else $error("end-of-frame word did not start the divider");

    // No pixel is taken while the divider or report stages are busy.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input ready while frame report is in progress");

    // A report without a match carries zeros in every statistic.
    a_empty_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_object_found) |->
            (o_match_count == '0) && (o_centroid_column == '0)
            && (o_centroid_row == '0) && (o_centroid_index == '0))
        else $error("empty frame reported nonzero statistics");

    // Statistics only appear on a frame-done word.
    a_stats_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_done) |-> !o_object_found)
        else $error("object flag outside frame end");

endmodule
